@@ hdl/b64e_pkg.sv @@
// b64e_pkg: shared types, constants and the character table of the
// base64url stream encoder. No dependencies.
package b64e_pkg;

  localparam int unsigned QueueDepthDefault = 4;
  localparam logic [15:0] CapacityReset     = 16'd64;

  // One unit of work for the back end: a group or tail of characters,
  // or a single overflow word.
  typedef struct packed {
    logic [23:0] group;      // MSB-aligned 24-bit group
    logic [1:0]  last_idx;   // number of characters minus one (1..3)
    logic        ovf;        // capacity exceeded: one overflow word only
    logic        last;       // group closes the message
  } b64e_job_t;

  localparam int unsigned JobWidth = $bits(b64e_job_t);

  // URL-safe alphabet: A-Z a-z 0-9 '-' '_'
  function automatic logic [7:0] b64e_char(input logic [5:0] idx);
    logic [7:0] c;
    c = {2'b00, idx};
    if (idx < 6'd26)       return 8'h41 + c;
    else if (idx < 6'd52)  return 8'h61 + c - 8'd26;
    else if (idx < 6'd62)  return 8'h30 + c - 8'd52;
    else if (idx == 6'd62) return 8'h2D;
    else                   return 8'h5F;
  endfunction

endpackage

@@ hdl/b64e_front.sv @@
// b64e_front: accepts bytes, collects them into groups, checks the
// capacity and pushes jobs into the queue. Depends on b64e_pkg.
module b64e_front import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_is_last,
  input  logic        q_full,
  output logic        push,
  output b64e_job_t   push_job
);

  logic [15:0] cap_r;
  logic [15:0] held_r, held_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic        failed_r, failed_nxt;

  logic        accept;
  logic [23:0] group;
  logic [1:0]  last_idx;
  logic [16:0] need;
  logic        fail;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    unique case (phase_r)
      2'd0:    begin group = {in_byte, 16'h0000};       last_idx = 2'd1; end
      2'd1:    begin group = {held_r[7:0], in_byte, 8'h00}; last_idx = 2'd2; end
      default: begin group = {held_r, in_byte};          last_idx = 2'd3; end
    endcase
  end

  // characters after this group; the terminator slot must still fit
  assign need = {1'b0, count_r} + {15'd0, last_idx} + 17'd1;
  assign fail = need >= {1'b0, cap_r};

  always_comb begin
    held_nxt   = held_r;
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    failed_nxt = failed_r;
    push       = 1'b0;
    push_job.group    = group;
    push_job.last_idx = last_idx;
    push_job.ovf      = fail;
    push_job.last     = in_is_last;
    if (accept) begin
      priority if (failed_r) begin
        if (in_is_last) begin
          held_nxt = '0; phase_nxt = '0; count_nxt = '0; failed_nxt = 1'b0;
        end
      end else if (phase_r != 2'd2 && !in_is_last) begin
        held_nxt  = {held_r[7:0], in_byte};
        phase_nxt = phase_r + 2'd1;
      end else begin
        push      = 1'b1;
        held_nxt  = '0;
        phase_nxt = '0;
        if (in_is_last) begin
          count_nxt = '0; failed_nxt = 1'b0;
        end else if (fail) begin
          failed_nxt = 1'b1;
        end else begin
          count_nxt = need[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CapacityReset;
      held_r   <= '0;
      phase_r  <= '0;
      count_r  <= '0;
      failed_r <= 1'b0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      held_r   <= held_nxt;
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

@@ hdl/b64e_queue.sv @@
// b64e_queue: short FIFO of jobs between front and back end.
// Depends on b64e_pkg.
module b64e_queue import b64e_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  b64e_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output b64e_job_t head
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

  b64e_job_t           mem_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;

  assign full  = count_r == CntW'(DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + CntW'(1);
        2'b01:   count_r <= count_r - CntW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

@@ hdl/b64e_back.sv @@
// b64e_back: walks the head job one character per cycle into the
// output register, unless out_ready holds it. Depends on b64e_pkg.
module b64e_back import b64e_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  b64e_job_t head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [7:0] out_symbol,
  output logic      out_end_of_message,
  output logic      out_overflow
);

  logic       valid_r;
  logic [1:0] idx_r;
  logic [7:0] sym_r;
  logic       eom_r, ovf_r;
  logic       load, last_char;
  logic [5:0] six;

  assign load      = !q_empty && (!valid_r || out_ready);
  assign last_char = head.ovf || (idx_r == head.last_idx);
  assign pop       = load && last_char;

  always_comb begin
    unique case (idx_r)
      2'd0:    six = head.group[23:18];
      2'd1:    six = head.group[17:12];
      2'd2:    six = head.group[11:6];
      default: six = head.group[5:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= last_char ? 2'd0 : idx_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // an overflow word always closes the message
  always_ff @(posedge clk) begin
    if (load) begin
      sym_r <= head.ovf ? 8'h00 : b64e_char(six);
      eom_r <= head.ovf || (head.last && last_char);
      ovf_r <= head.ovf;
    end
  end

  assign out_valid          = valid_r;
  assign out_symbol         = sym_r;
  assign out_end_of_message = eom_r;
  assign out_overflow       = ovf_r;

endmodule

@@ hdl/base64url_stream_encoder_core.sv @@
// base64url_stream_encoder_core: top level of the unpadded base64url
// stream encoder. Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
//
// Bytes enter one per word on the in_ channel; every three bytes leave as four
// URL-safe characters on the out_ channel, a tail of one or two bytes as two or
// three characters, the last character flagged end_of_message. If a group would
// leave no room for the terminator within cfg capacity, one word with overflow
// and end_of_message set (symbol 0) is given and the rest of the message is
// dropped. The front end takes a byte every cycle while the job queue has room;
// the back end sends one character per cycle while out_ready allows, so the
// output port sets the sustained rate. With an empty queue the first character
// of a group reaches the output through the queue and the output register.
// Write the capacity only while the block is idle.
module base64url_stream_encoder_core import b64e_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_symbol,
  output logic        out_end_of_message,
  output logic        out_overflow
);

  logic      push, pop, q_full, q_empty;
  b64e_job_t push_job, head;

  b64e_front u_front (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_valid, .in_ready, .in_byte, .in_is_last,
    .q_full, .push, .push_job
  );

  b64e_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push, .push_job, .full(q_full),
    .pop, .empty(q_empty), .head
  );

  b64e_back u_back (
    .clk, .rst_n, .q_empty, .head, .pop,
    .out_valid, .out_ready, .out_symbol, .out_end_of_message, .out_overflow
  );

endmodule
